[design/osv_pkg.sv]
// Shared types and constants for the odd-only prime sieve.
// No dependencies; imported by every module of the block.
package osv_pkg;

  localparam int FIELD_W       = 20;
  localparam int FIELD_MAX     = 1048575;
  localparam int MAX_VALUE_DEF = 1048575;

  localparam int SLOT_W     = FIELD_W - 1;
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = 6;
  localparam int WORD_W     = SLOT_W - BIT_W;
  localparam int GROUP_BITS = 8;
  localparam int GROUPS     = WORD_BITS / GROUP_BITS;
  localparam int GIDX_W     = 3;
  localparam int GSEL_W     = 3;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] range_low;
    logic [FIELD_W-1:0] range_high;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0] prime_value;
    logic               found;
    logic               is_last;
  } res_t;

endpackage

[design/osv_bitmap_ram.sv]
// Composite bitmap store: one write port, one registered read port.
// Depends on osv_pkg.
module osv_bitmap_ram import osv_pkg::*; #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/osv_word_search.sv]
// Two-stage find-first-free-slot search over one bitmap word.
// Depends on osv_pkg.
module osv_word_search import osv_pkg::*; (
  input  logic                 clk,
  input  logic [WORD_BITS-1:0] rd_data,
  input  logic [BIT_W-1:0]     lo_bit,
  input  logic                 lim_en,
  input  logic [BIT_W-1:0]     lim_bit,
  output logic                 hit,
  output logic [BIT_W-1:0]     hit_idx
);

  logic [WORD_BITS-1:0]          free;
  logic [WORD_BITS-1:0]          lo_mask;
  logic [WORD_BITS-1:0]          hi_mask;
  logic [GROUPS-1:0]             grp_any;
  logic [GROUPS-1:0][GIDX_W-1:0] grp_idx;
  logic [GROUPS-1:0]             grp_any_r;
  logic [GROUPS-1:0][GIDX_W-1:0] grp_idx_r;

  always_comb begin
    lo_mask = {WORD_BITS{1'b1}} << lo_bit;
    hi_mask = lim_en ? ~({WORD_BITS{1'b1}} << lim_bit) : {WORD_BITS{1'b1}};
    free    = ~rd_data & lo_mask & hi_mask;
    for (int g = 0; g < GROUPS; g++) begin
      grp_any[g] = |free[g*GROUP_BITS +: GROUP_BITS];
      grp_idx[g] = '0;
      for (int j = GROUP_BITS - 1; j >= 0; j--) begin
        if (free[g*GROUP_BITS + j]) begin
          grp_idx[g] = GIDX_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any;
    grp_idx_r <= grp_idx;
  end

  always_comb begin
    hit     = |grp_any_r;
    hit_idx = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        hit_idx = {GSEL_W'(g), grp_idx_r[g]};
      end
    end
  end

endmodule

[design/osv_engine.sv]
// Sieve sequencer: bitmap clear, striking, and scan for the next prime.
// Depends on osv_pkg, osv_bitmap_ram and osv_word_search.
module osv_engine import osv_pkg::*; #(
  parameter int MAX_VALUE = MAX_VALUE_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_ready,
  output logic res_valid,
  output res_t res,
  input  logic res_ready
);

  localparam int LIMIT      = (MAX_VALUE < FIELD_MAX) ? MAX_VALUE : FIELD_MAX;
  localparam int SLOT_COUNT = (LIMIT - 1) / 2;
  localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int MEM_AW     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam logic [FIELD_W-1:0] LIMIT_V = FIELD_W'(LIMIT);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_CHK_RD = 4'd2;
  localparam logic [3:0] S_CHK_EV = 4'd3;
  localparam logic [3:0] S_MK_RD  = 4'd4;
  localparam logic [3:0] S_MK_WR  = 4'd5;
  localparam logic [3:0] S_SC_RD  = 4'd6;
  localparam logic [3:0] S_SC_S1  = 4'd7;
  localparam logic [3:0] S_SC_S2  = 4'd8;
  localparam logic [3:0] S_RESP   = 4'd9;

  logic [3:0]         state_r,   state_nxt;
  logic               two_r,     two_nxt;
  logic [SLOT_W-1:0]  top_r,     top_nxt;
  logic [SLOT_W-1:0]  nxt_r,     nxt_nxt;
  logic               fetch_r,   fetch_nxt;
  logic [SLOT_W-1:0]  from_r,    from_nxt;
  logic [FIELD_W-1:0] hi_r,      hi_nxt;
  logic [10:0]        i_r,       i_nxt;
  logic [FIELD_W:0]   isq_r,     isq_nxt;
  logic [FIELD_W:0]   p_r,       p_nxt;
  logic [WORD_W:0]    clr_cnt_r, clr_cnt_nxt;
  res_t               res_r,     res_nxt;

  logic                 mem_rd;
  logic [MEM_AW-1:0]    mem_rd_addr;
  logic [WORD_BITS-1:0] mem_rd_data;
  logic                 mem_wr;
  logic [MEM_AW-1:0]    mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;

  logic               srch_hit;
  logic [BIT_W-1:0]   srch_idx;
  logic               scan_done;
  logic               scan_hit;

  logic [FIELD_W-1:0] hi_sat;
  logic               cmd_empty;
  logic [FIELD_W-1:0] nwords_sum;
  logic [WORD_W:0]    nwords;
  logic [SLOT_W-1:0]  i_slot;
  logic [WORD_W-1:0]  i_word;
  logic [SLOT_W-1:0]  p_slot;
  logic [WORD_W-1:0]  p_word;
  logic [WORD_W-1:0]  from_word;
  logic [WORD_W-1:0]  top_word;
  logic [FIELD_W:0]   isq_adv;

  assign hi_sat     = (cmd.range_high > LIMIT_V) ? LIMIT_V : cmd.range_high;
  assign cmd_empty  = (hi_sat < FIELD_W'(2)) || (cmd.range_low > hi_sat);
  assign nwords_sum = {1'b0, top_r} + FIELD_W'(WORD_BITS - 1);
  assign nwords     = nwords_sum[FIELD_W-1:BIT_W];
  assign i_slot     = {{(SLOT_W-10){1'b0}}, i_r[10:1]} - SLOT_W'(1);
  assign i_word     = i_slot[SLOT_W-1:BIT_W];
  assign p_slot     = p_r[FIELD_W-1:1] - SLOT_W'(1);
  assign p_word     = p_slot[SLOT_W-1:BIT_W];
  assign from_word  = from_r[SLOT_W-1:BIT_W];
  assign top_word   = top_r[SLOT_W-1:BIT_W];
  // (i+2)^2 = i^2 + 4i + 4
  assign isq_adv    = isq_r + {{(FIELD_W-12){1'b0}}, i_r, 2'b00} + (FIELD_W+1)'(4);

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

  osv_bitmap_ram #(
    .DEPTH (WORD_COUNT),
    .AW    (MEM_AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (mem_rd),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  osv_word_search u_search (
    .clk     (clk),
    .rd_data (mem_rd_data),
    .lo_bit  (from_r[BIT_W-1:0]),
    .lim_en  (from_word == top_word),
    .lim_bit (top_r[BIT_W-1:0]),
    .hit     (srch_hit),
    .hit_idx (srch_idx)
  );

  always_comb begin
    state_nxt   = state_r;
    two_nxt     = two_r;
    top_nxt     = top_r;
    nxt_nxt     = nxt_r;
    fetch_nxt   = fetch_r;
    from_nxt    = from_r;
    hi_nxt      = hi_r;
    i_nxt       = i_r;
    isq_nxt     = isq_r;
    p_nxt       = p_r;
    clr_cnt_nxt = clr_cnt_r;
    res_nxt     = res_r;
    mem_rd      = 1'b0;
    mem_rd_addr = '0;
    mem_wr      = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    scan_done   = 1'b0;
    scan_hit    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.func == FUNC_START) begin
            if (cmd_empty) begin
              two_nxt = 1'b0;
              top_nxt = '0;
              nxt_nxt = '0;
            end else begin
              two_nxt     = (cmd.range_low <= FIELD_W'(2));
              top_nxt     = hi_sat[FIELD_W-1:1] - {{(SLOT_W-1){1'b0}}, ~hi_sat[0]};
              from_nxt    = (cmd.range_low > FIELD_W'(2))
                          ? cmd.range_low[FIELD_W-1:1] - SLOT_W'(1) : '0;
              hi_nxt      = hi_sat;
              i_nxt       = 11'd3;
              isq_nxt     = (FIELD_W+1)'(9);
              clr_cnt_nxt = '0;
              state_nxt   = S_CLR;
            end
          end else begin
            if (two_r) begin
              two_nxt             = 1'b0;
              res_nxt.prime_value = FIELD_W'(2);
              res_nxt.found       = 1'b1;
              res_nxt.is_last     = (nxt_r >= top_r);
              state_nxt           = S_RESP;
            end else if (nxt_r >= top_r) begin
              res_nxt   = '0;
              state_nxt = S_RESP;
            end else begin
              res_nxt.prime_value = {nxt_r, 1'b1} + FIELD_W'(2);
              res_nxt.found       = 1'b1;
              res_nxt.is_last     = 1'b0;
              from_nxt            = nxt_r + SLOT_W'(1);
              fetch_nxt           = 1'b1;
              state_nxt           = S_SC_RD;
            end
          end
        end
      end
      S_CLR: begin
        if (clr_cnt_r == nwords) begin
          state_nxt = S_CHK_RD;
        end else begin
          mem_wr      = 1'b1;
          mem_wr_addr = clr_cnt_r[MEM_AW-1:0];
          clr_cnt_nxt = clr_cnt_r + (WORD_W+1)'(1);
        end
      end
      S_CHK_RD: begin
        if (isq_r > {1'b0, hi_r}) begin
          fetch_nxt = 1'b0;
          state_nxt = S_SC_RD;
        end else begin
          mem_rd      = 1'b1;
          mem_rd_addr = i_word[MEM_AW-1:0];
          state_nxt   = S_CHK_EV;
        end
      end
      S_CHK_EV: begin
        if (mem_rd_data[i_slot[BIT_W-1:0]]) begin
          i_nxt     = i_r + 11'd2;
          isq_nxt   = isq_adv;
          state_nxt = S_CHK_RD;
        end else begin
          p_nxt     = isq_r;
          state_nxt = S_MK_RD;
        end
      end
      S_MK_RD: begin
        if (p_r > {1'b0, hi_r}) begin
          i_nxt     = i_r + 11'd2;
          isq_nxt   = isq_adv;
          state_nxt = S_CHK_RD;
        end else begin
          mem_rd      = 1'b1;
          mem_rd_addr = p_word[MEM_AW-1:0];
          state_nxt   = S_MK_WR;
        end
      end
      S_MK_WR: begin
        mem_wr      = 1'b1;
        mem_wr_addr = p_word[MEM_AW-1:0];
        mem_wr_data = mem_rd_data | ({{(WORD_BITS-1){1'b0}}, 1'b1} << p_slot[BIT_W-1:0]);
        p_nxt       = p_r + {{(FIELD_W-11){1'b0}}, i_r, 1'b0};
        state_nxt   = S_MK_RD;
      end
      S_SC_RD: begin
        if (from_r >= top_r) begin
          nxt_nxt   = top_r;
          scan_done = 1'b1;
        end else begin
          mem_rd      = 1'b1;
          mem_rd_addr = from_word[MEM_AW-1:0];
          state_nxt   = S_SC_S1;
        end
      end
      S_SC_S1: begin
        state_nxt = S_SC_S2;
      end
      S_SC_S2: begin
        if (srch_hit) begin
          nxt_nxt   = {from_word, srch_idx};
          scan_done = 1'b1;
          scan_hit  = 1'b1;
        end else if (from_word == top_word) begin
          nxt_nxt   = top_r;
          scan_done = 1'b1;
        end else begin
          from_nxt  = {from_word + WORD_W'(1), {BIT_W{1'b0}}};
          state_nxt = S_SC_RD;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (scan_done) begin
      if (fetch_r) begin
        res_nxt.is_last = !scan_hit;
        state_nxt       = S_RESP;
      end else begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      two_r   <= 1'b0;
      top_r   <= '0;
      nxt_r   <= '0;
      fetch_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      two_r   <= two_nxt;
      top_r   <= top_nxt;
      nxt_r   <= nxt_nxt;
      fetch_r <= fetch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    from_r    <= from_nxt;
    hi_r      <= hi_nxt;
    i_r       <= i_nxt;
    isq_r     <= isq_nxt;
    p_r       <= p_nxt;
    clr_cnt_r <= clr_cnt_nxt;
    res_r     <= res_nxt;
  end

`ifndef NO_ASSERTIONS
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd && mem_wr))
    else $error("bitmap read and write in the same cycle");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (nxt_r <= top_r))
    else $error("next-prime cursor beyond sieve top");

  a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MK_WR) |-> (p_slot < top_r))
    else $error("strike outside sieved slots");

  a_prime_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_r.found && (res_r.prime_value != FIELD_W'(2)))
      |-> res_r.prime_value[0])
    else $error("even value reported as prime");
`endif

endmodule

[design/odd_only_prime_sieve_top.sv]
// Odd-only prime sieve, top level: stream ports and output register.
// Depends on osv_pkg and osv_engine.
//
//  channel | dir | tdata                                  | tuser     | tlast
//  in_     | in  | [19:0] range_low, [39:20] range_high   | [0] func  | -
//  out_    | out | [19:0] prime_value, [23:20] zero       | [0] found | is_last
//
// Fetch: a pending 2 or an exhausted range is answered at once; otherwise the
//   stored next prime is answered after a scan for the one after it (read,
//   search stages S1 and S2 per bitmap word), ending when no slot is left.
// Start: clear of ceil(top/64) bitmap words, a check of each odd candidate up to
//   sqrt(high), a read-modify-write per struck multiple, then one scan.
// The bitmap memory is cleared by each non-empty start; reset clears control state only.
// in_tready is low while the sequencer is busy or a result waits for the
// output register.
module odd_only_prime_sieve_top import osv_pkg::*; #(
  parameter int MAX_VALUE = MAX_VALUE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [19:0] range_low, [39:20] range_high
  input  logic [0:0]            in_tuser,   // [0] func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [19:0] prime_value, [23:20] zero
  output logic [0:0]            out_tuser,  // [0] found
  output logic                  out_tlast
);

  cmd_t cmd;
  logic cmd_ready;
  logic res_valid;
  res_t res;
  logic res_ready;
  logic out_valid_r;
  res_t out_res_r;

  assign cmd.func       = in_tuser[0];
  assign cmd.range_low  = in_tdata[FIELD_W-1:0];
  assign cmd.range_high = in_tdata[2*FIELD_W-1:FIELD_W];
  assign in_tready      = cmd_ready;

  osv_engine #(
    .MAX_VALUE (MAX_VALUE)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-FIELD_W){1'b0}}, out_res_r.prime_value};
  assign out_tuser  = out_res_r.found;
  assign out_tlast  = out_res_r.is_last;

endmodule
